### rtl/core/tcnc_pkg.sv
// ----------------------------------------------------------------------------
// tcnc_pkg
// Shared types, widths and codes of the two-cluster nearest-centroid block.
// ----------------------------------------------------------------------------
package tcnc_pkg;

  localparam int CoordW  = 8;
  localparam int SumW    = 18;
  localparam int CntW    = 11;
  localparam int CntMax  = 2047;
  localparam int ProdW   = 19;
  localparam int DistW   = 39;
  localparam int MulW    = 22;
  localparam int SplitW  = 20;
  localparam int HiW     = DistW - SplitW;
  localparam int TermW   = 61;
  localparam int PartW   = SplitW + MulW;
  localparam int HiProdW = HiW + MulW;

  localparam int DefMaxPoints = 1024;
  localparam int DefCoordBits = 8;

  typedef enum logic [1:0] {
    CMD_ADD_A    = 2'd0,
    CMD_ADD_B    = 2'd1,
    CMD_CLASSIFY = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    VERDICT_A     = 2'd0,
    VERDICT_B     = 2'd1,
    VERDICT_TIE   = 2'd2,
    VERDICT_EMPTY = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    STP_MUL_AX,
    STP_MUL_AY,
    STP_SQ_DAX,
    STP_SQ_DAY,
    STP_MUL_BX,
    STP_MUL_BY,
    STP_SQ_DBX,
    STP_SQ_DBY,
    STP_SQ_CA,
    STP_SQ_CB,
    STP_TA_LO,
    STP_TA_HI,
    STP_TB_LO,
    STP_TB_HI,
    STP_TB_SUM,
    STP_CMP
  } step_t;

  typedef struct packed {
    logic [SumW-1:0] sum_ax;
    logic [SumW-1:0] sum_ay;
    logic [SumW-1:0] sum_bx;
    logic [SumW-1:0] sum_by;
    logic [CntW-1:0] count_a;
    logic [CntW-1:0] count_b;
  } stats_t;

endpackage

### rtl/core/tcnc_mul.sv
// ----------------------------------------------------------------------------
// tcnc_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module tcnc_mul (
  input  logic                        clk,
  input  logic [tcnc_pkg::MulW-1:0]   a,
  input  logic [tcnc_pkg::MulW-1:0]   b,
  output logic [2*tcnc_pkg::MulW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### rtl/core/tcnc_store.sv
// ----------------------------------------------------------------------------
// tcnc_store
// Coordinate sums and point counts of both clusters; add and clear words.
// ----------------------------------------------------------------------------
module tcnc_store #(
  parameter int MAX_POINTS = tcnc_pkg::DefMaxPoints
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr,
  input  tcnc_pkg::cmd_t                cmd,
  input  logic [tcnc_pkg::CoordW-1:0]   x,
  input  logic [tcnc_pkg::CoordW-1:0]   y,
  output tcnc_pkg::stats_t              stats
);

  localparam logic [tcnc_pkg::CntW-1:0] Limit = tcnc_pkg::CntW'(
    (MAX_POINTS < tcnc_pkg::CntMax) ? MAX_POINTS : tcnc_pkg::CntMax);

  logic [tcnc_pkg::SumW:0] ax_sum, ay_sum, bx_sum, by_sum;
  logic                    ok_a, ok_b;

  assign ax_sum = {1'b0, stats.sum_ax} + (tcnc_pkg::SumW+1)'(x);
  assign ay_sum = {1'b0, stats.sum_ay} + (tcnc_pkg::SumW+1)'(y);
  assign bx_sum = {1'b0, stats.sum_bx} + (tcnc_pkg::SumW+1)'(x);
  assign by_sum = {1'b0, stats.sum_by} + (tcnc_pkg::SumW+1)'(y);

  assign ok_a = (stats.count_a < Limit) && !ax_sum[tcnc_pkg::SumW]
                && !ay_sum[tcnc_pkg::SumW];
  assign ok_b = (stats.count_b < Limit) && !bx_sum[tcnc_pkg::SumW]
                && !by_sum[tcnc_pkg::SumW];

  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else if (wr) begin
      case (cmd)
        tcnc_pkg::CMD_ADD_A: begin
          if (ok_a) begin
            stats.count_a <= stats.count_a + 1'b1;
            stats.sum_ax  <= ax_sum[tcnc_pkg::SumW-1:0];
            stats.sum_ay  <= ay_sum[tcnc_pkg::SumW-1:0];
          end
        end
        tcnc_pkg::CMD_ADD_B: begin
          if (ok_b) begin
            stats.count_b <= stats.count_b + 1'b1;
            stats.sum_bx  <= bx_sum[tcnc_pkg::SumW-1:0];
            stats.sum_by  <= by_sum[tcnc_pkg::SumW-1:0];
          end
        end
        tcnc_pkg::CMD_CLEAR: begin
          stats <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/tcnc_seq.sv
// ----------------------------------------------------------------------------
// tcnc_seq
// Classify sequencer: drives the shared multiplier through sixteen steps,
// forms both scaled distances and cross terms, and holds the result word.
// ----------------------------------------------------------------------------
module tcnc_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  tcnc_pkg::cmd_t                cmd,
  input  logic [tcnc_pkg::CoordW-1:0]   x,
  input  logic [tcnc_pkg::CoordW-1:0]   y,
  input  tcnc_pkg::stats_t              stats,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tcnc_pkg::verdict_t            verdict,
  output logic [tcnc_pkg::MulW-1:0]     mul_a,
  output logic [tcnc_pkg::MulW-1:0]     mul_b,
  input  logic [2*tcnc_pkg::MulW-1:0]   mul_p
);

  tcnc_pkg::state_t   state, state_next;
  tcnc_pkg::step_t    step;
  tcnc_pkg::verdict_t result;

  logic [tcnc_pkg::CoordW-1:0]  qx, qy;
  logic [tcnc_pkg::ProdW-1:0]   dreg;
  logic [tcnc_pkg::DistW-1:0]   acc, dist_a;
  logic [tcnc_pkg::MulW-1:0]    sq_a, sq_b;
  logic [tcnc_pkg::PartW-1:0]   part;
  logic [tcnc_pkg::TermW-1:0]   ta, tb;
  logic [tcnc_pkg::ProdW-1:0]   sum_sel, diff;
  logic [tcnc_pkg::TermW-1:0]   term;
  logic                         accept, classify, empty, load_out, last_step;

  assign accept    = in_valid && !in_stall;
  assign classify  = accept && (cmd == tcnc_pkg::CMD_CLASSIFY);
  assign empty     = (stats.count_a == '0) || (stats.count_b == '0);
  assign last_step = (step == tcnc_pkg::STP_CMP);

  always_comb begin
    state_next = state;
    unique case (state)
      tcnc_pkg::ST_IDLE: begin
        if (classify) begin
          state_next = empty ? tcnc_pkg::ST_DONE : tcnc_pkg::ST_CALC;
        end
      end
      tcnc_pkg::ST_CALC: begin
        if (last_step) begin
          state_next = tcnc_pkg::ST_DONE;
        end
      end
      tcnc_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = tcnc_pkg::ST_IDLE;
        end
      end
      default: state_next = tcnc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != tcnc_pkg::ST_IDLE);
    load_out = (state == tcnc_pkg::ST_DONE) && (!out_valid || !out_stall);
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    sum_sel = '0;
    unique case (step) inside
      tcnc_pkg::STP_MUL_AX: begin
        mul_a = tcnc_pkg::MulW'(stats.count_a);
        mul_b = tcnc_pkg::MulW'(qx);
      end
      tcnc_pkg::STP_MUL_AY: begin
        mul_a   = tcnc_pkg::MulW'(stats.count_a);
        mul_b   = tcnc_pkg::MulW'(qy);
        sum_sel = tcnc_pkg::ProdW'(stats.sum_ax);
      end
      tcnc_pkg::STP_SQ_DAX: begin
        mul_a   = tcnc_pkg::MulW'(dreg);
        mul_b   = tcnc_pkg::MulW'(dreg);
        sum_sel = tcnc_pkg::ProdW'(stats.sum_ay);
      end
      tcnc_pkg::STP_SQ_DAY, tcnc_pkg::STP_SQ_DBY: begin
        mul_a = tcnc_pkg::MulW'(dreg);
        mul_b = tcnc_pkg::MulW'(dreg);
      end
      tcnc_pkg::STP_MUL_BX: begin
        mul_a = tcnc_pkg::MulW'(stats.count_b);
        mul_b = tcnc_pkg::MulW'(qx);
      end
      tcnc_pkg::STP_MUL_BY: begin
        mul_a   = tcnc_pkg::MulW'(stats.count_b);
        mul_b   = tcnc_pkg::MulW'(qy);
        sum_sel = tcnc_pkg::ProdW'(stats.sum_bx);
      end
      tcnc_pkg::STP_SQ_DBX: begin
        mul_a   = tcnc_pkg::MulW'(dreg);
        mul_b   = tcnc_pkg::MulW'(dreg);
        sum_sel = tcnc_pkg::ProdW'(stats.sum_by);
      end
      tcnc_pkg::STP_SQ_CA: begin
        mul_a = tcnc_pkg::MulW'(stats.count_a);
        mul_b = tcnc_pkg::MulW'(stats.count_a);
      end
      tcnc_pkg::STP_SQ_CB: begin
        mul_a = tcnc_pkg::MulW'(stats.count_b);
        mul_b = tcnc_pkg::MulW'(stats.count_b);
      end
      tcnc_pkg::STP_TA_LO: begin
        mul_a = tcnc_pkg::MulW'(dist_a[tcnc_pkg::SplitW-1:0]);
        mul_b = mul_p[tcnc_pkg::MulW-1:0];
      end
      tcnc_pkg::STP_TA_HI: begin
        mul_a = tcnc_pkg::MulW'(dist_a[tcnc_pkg::DistW-1:tcnc_pkg::SplitW]);
        mul_b = sq_b;
      end
      tcnc_pkg::STP_TB_LO: begin
        mul_a = tcnc_pkg::MulW'(acc[tcnc_pkg::SplitW-1:0]);
        mul_b = sq_a;
      end
      tcnc_pkg::STP_TB_HI: begin
        mul_a = tcnc_pkg::MulW'(acc[tcnc_pkg::DistW-1:tcnc_pkg::SplitW]);
        mul_b = sq_a;
      end
      tcnc_pkg::STP_TB_SUM, tcnc_pkg::STP_CMP: begin
      end
      default: begin
      end
    endcase
  end

  assign diff = (mul_p[tcnc_pkg::ProdW-1:0] >= sum_sel)
                ? mul_p[tcnc_pkg::ProdW-1:0] - sum_sel
                : sum_sel - mul_p[tcnc_pkg::ProdW-1:0];

  assign term = tcnc_pkg::TermW'(part)
                + (tcnc_pkg::TermW'(mul_p[tcnc_pkg::HiProdW-1:0]) << tcnc_pkg::SplitW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcnc_pkg::ST_IDLE;
      step      <= tcnc_pkg::STP_MUL_AX;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tcnc_pkg::ST_CALC) begin
        step <= last_step ? tcnc_pkg::STP_MUL_AX : tcnc_pkg::step_t'(step + 1'b1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      qx <= x;
      qy <= y;
    end
    if (classify && empty) begin
      result <= tcnc_pkg::VERDICT_EMPTY;
    end
    if (load_out) begin
      verdict <= result;
    end
    if (state == tcnc_pkg::ST_CALC) begin
      case (step) inside
        tcnc_pkg::STP_MUL_AY, tcnc_pkg::STP_SQ_DAX,
        tcnc_pkg::STP_MUL_BY, tcnc_pkg::STP_SQ_DBX: dreg <= diff;
        tcnc_pkg::STP_SQ_DAY, tcnc_pkg::STP_SQ_DBY:
          acc <= mul_p[tcnc_pkg::DistW-1:0];
        tcnc_pkg::STP_MUL_BX, tcnc_pkg::STP_SQ_CA:
          acc <= acc + mul_p[tcnc_pkg::DistW-1:0];
        default: begin
        end
      endcase
      case (step) inside
        tcnc_pkg::STP_MUL_BY: dist_a <= acc;
        tcnc_pkg::STP_SQ_CB:  sq_a   <= mul_p[tcnc_pkg::MulW-1:0];
        tcnc_pkg::STP_TA_LO:  sq_b   <= mul_p[tcnc_pkg::MulW-1:0];
        tcnc_pkg::STP_TA_HI, tcnc_pkg::STP_TB_HI:
          part <= mul_p[tcnc_pkg::PartW-1:0];
        tcnc_pkg::STP_TB_LO:  ta <= term;
        tcnc_pkg::STP_TB_SUM: tb <= term;
        tcnc_pkg::STP_CMP: begin
          if (ta == tb) begin
            result <= tcnc_pkg::VERDICT_TIE;
          end else if (ta < tb) begin
            result <= tcnc_pkg::VERDICT_A;
          end else begin
            result <= tcnc_pkg::VERDICT_B;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_calc_ends: assert property (@(posedge clk) disable iff (rst)
    (state == tcnc_pkg::ST_CALC && last_step) |=> (state == tcnc_pkg::ST_DONE))
    else $error("sequencer did not finish after the compare step");

  a_empty_short: assert property (@(posedge clk) disable iff (rst)
    (classify && empty) |=> (state == tcnc_pkg::ST_DONE
                             && result == tcnc_pkg::VERDICT_EMPTY))
    else $error("empty cluster classify did not short cut");

  a_stats_hold: assert property (@(posedge clk) disable iff (rst)
    (state == tcnc_pkg::ST_CALC) |-> $stable(stats))
    else $error("cluster state changed during classify");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == tcnc_pkg::ST_DONE))
    else $error("result word appeared without a finished classify");

endmodule

### rtl/core/two_cluster_nearest_centroid.sv
// ----------------------------------------------------------------------------
// two_cluster_nearest_centroid
// Two-cluster nearest-centroid classifier.
//
// Input channel (in_valid / in_stall) carries one command word: cmd, x_coord,
// y_coord. Add words put the point into cluster A or B (ignored when the
// cluster is full or a coordinate sum would overflow 18 bits); a clear word
// empties both clusters. Add and clear give no result.
// A classify word gives one verdict word on the output channel (out_valid /
// out_stall): 0 nearer A, 1 nearer B, 2 equal distance, 3 a cluster empty.
// With a cluster empty the sequencer goes straight to the output load;
// otherwise it runs sixteen sequencer steps (four coordinate products,
// four squares, two count squares and four half cross products on the one
// shared 22x22 multiplier, then a final sum and the compare) and the output
// load. in_stall is high while a classify is in progress, so a classify
// holds the input until its verdict is loaded. A result waiting on a stalled receiver
// is held in the output register; a later classify then holds in its final
// state until that register is taken.
// Reset clears all sums, counts and the output valid flag.
// ----------------------------------------------------------------------------
module two_cluster_nearest_centroid #(
  parameter int MAX_POINTS = tcnc_pkg::DefMaxPoints,
  parameter int COORD_BITS = tcnc_pkg::DefCoordBits
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  cmd,
  input  logic [tcnc_pkg::CoordW-1:0] x_coord,
  input  logic [tcnc_pkg::CoordW-1:0] y_coord,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  verdict
);

  localparam logic [tcnc_pkg::CoordW-1:0] CoordMask = tcnc_pkg::CoordW'(
    (COORD_BITS >= tcnc_pkg::CoordW) ? ((1 << tcnc_pkg::CoordW) - 1)
                                     : ((1 << COORD_BITS) - 1));

  logic [tcnc_pkg::CoordW-1:0]   x_m, y_m;
  logic [tcnc_pkg::MulW-1:0]     mul_a, mul_b;
  logic [2*tcnc_pkg::MulW-1:0]   mul_p;
  tcnc_pkg::stats_t              stats;
  tcnc_pkg::cmd_t                cmd_c;
  tcnc_pkg::verdict_t            verdict_c;
  logic                          wr;

  assign x_m     = x_coord & CoordMask;
  assign y_m     = y_coord & CoordMask;
  assign cmd_c   = tcnc_pkg::cmd_t'(cmd);
  assign wr      = in_valid && !in_stall;
  assign verdict = verdict_c;

  tcnc_store #(
    .MAX_POINTS(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .cmd  (cmd_c),
    .x    (x_m),
    .y    (y_m),
    .stats(stats)
  );

  tcnc_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  tcnc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd_c),
    .x        (x_m),
    .y        (y_m),
    .stats    (stats),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict  (verdict_c),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .mul_p    (mul_p)
  );

endmodule

### verif/tb_two_cluster_nearest_centroid.sv
// ----------------------------------------------------------------------------
// tb_two_cluster_nearest_centroid
// Self-checking bench for the two-cluster nearest-centroid block. A queue of
// command words is sent with random gaps. Every accepted word updates a local
// copy of the cluster sums and counts. A classify word computes the expected
// verdict by exact cross-multiplication of the scaled squared distances.
// Verdict words are taken with random stalls and one long hold-off, and each
// one is compared in order with the oldest expected verdict.
// ----------------------------------------------------------------------------
module tb_two_cluster_nearest_centroid;

  localparam int MaxPts = tcnc_pkg::DefMaxPoints;
  localparam logic [tcnc_pkg::CoordW-1:0] CoordMask =
    tcnc_pkg::CoordW'((1 << tcnc_pkg::DefCoordBits) - 1);
  localparam int SumMax = (1 << tcnc_pkg::SumW) - 1;
  localparam int CycleLimit = 1000000;
  localparam int HoldCycles = 400;

  typedef struct {
    tcnc_pkg::cmd_t              op;
    logic [tcnc_pkg::CoordW-1:0] x;
    logic [tcnc_pkg::CoordW-1:0] y;
  } word_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  cmd = 2'd0;
  logic [tcnc_pkg::CoordW-1:0] x_coord = '0;
  logic [tcnc_pkg::CoordW-1:0] y_coord = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  verdict;

  two_cluster_nearest_centroid dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .verdict   (verdict)
  );

  word_t              word_q[$];
  tcnc_pkg::verdict_t verdict_q[$];
  word_t              next_word;

  logic [tcnc_pkg::SumW-1:0] sum_ax = '0, sum_ay = '0, sum_bx = '0, sum_by = '0;
  logic [tcnc_pkg::CntW-1:0] count_a = '0, count_b = '0;

  int errors = 0;
  int words_total = 0;
  int words_taken = 0;
  int verdicts_seen = 0;
  int cycles = 0;
  int send_gap = 0, send_calm = 0;
  int recv_gap = 0, recv_calm = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic stall_nxt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [127:0] scaled_span(logic [tcnc_pkg::CntW-1:0] n,
                                               logic [tcnc_pkg::SumW-1:0] sx,
                                               logic [tcnc_pkg::SumW-1:0] sy,
                                               logic [tcnc_pkg::CoordW-1:0] px,
                                               logic [tcnc_pkg::CoordW-1:0] py);
    logic [127:0] nx, ny, dx, dy;
    nx = 128'(n) * 128'(px);
    ny = 128'(n) * 128'(py);
    dx = (nx >= 128'(sx)) ? nx - 128'(sx) : 128'(sx) - nx;
    dy = (ny >= 128'(sy)) ? ny - 128'(sy) : 128'(sy) - ny;
    return dx * dx + dy * dy;
  endfunction

  function automatic tcnc_pkg::verdict_t nearer_cluster(logic [tcnc_pkg::CoordW-1:0] px,
                                                        logic [tcnc_pkg::CoordW-1:0] py);
    logic [127:0] ta, tb;
    if (count_a == '0 || count_b == '0) return tcnc_pkg::VERDICT_EMPTY;
    ta = scaled_span(count_a, sum_ax, sum_ay, px, py) * (128'(count_b) * 128'(count_b));
    tb = scaled_span(count_b, sum_bx, sum_by, px, py) * (128'(count_a) * 128'(count_a));
    if (ta == tb) return tcnc_pkg::VERDICT_TIE;
    if (ta < tb) return tcnc_pkg::VERDICT_A;
    return tcnc_pkg::VERDICT_B;
  endfunction

  task automatic add_point(inout logic [tcnc_pkg::CntW-1:0] n,
                           inout logic [tcnc_pkg::SumW-1:0] sx,
                           inout logic [tcnc_pkg::SumW-1:0] sy,
                           input logic [tcnc_pkg::CoordW-1:0] px,
                           input logic [tcnc_pkg::CoordW-1:0] py);
    if (int'(n) >= MaxPts || int'(n) >= tcnc_pkg::CntMax) return;
    if (int'(sx) + int'(px) > SumMax || int'(sy) + int'(py) > SumMax) return;
    n  = n + 1'b1;
    sx = sx + tcnc_pkg::SumW'(px);
    sy = sy + tcnc_pkg::SumW'(py);
  endtask

  task automatic absorb_word(tcnc_pkg::cmd_t op, logic [tcnc_pkg::CoordW-1:0] px,
                             logic [tcnc_pkg::CoordW-1:0] py);
    logic [tcnc_pkg::CoordW-1:0] mx, my;
    mx = px & CoordMask;
    my = py & CoordMask;
    case (op)
      tcnc_pkg::CMD_ADD_A: add_point(count_a, sum_ax, sum_ay, mx, my);
      tcnc_pkg::CMD_ADD_B: add_point(count_b, sum_bx, sum_by, mx, my);
      tcnc_pkg::CMD_CLEAR: begin
        sum_ax = '0; sum_ay = '0; sum_bx = '0; sum_by = '0;
        count_a = '0; count_b = '0;
      end
      default: verdict_q.push_back(nearer_cluster(mx, my));
    endcase
  endtask

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic push_word(tcnc_pkg::cmd_t op, logic [tcnc_pkg::CoordW-1:0] px,
                           logic [tcnc_pkg::CoordW-1:0] py);
    word_t w;
    w.op = op;
    w.x  = px;
    w.y  = py;
    word_q.push_back(w);
    words_total++;
  endtask

  function automatic logic [tcnc_pkg::CoordW-1:0] pick_coord(bit narrow);
    if (narrow) return tcnc_pkg::CoordW'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return tcnc_pkg::CoordW'($urandom_range(0, (1 << tcnc_pkg::CoordW) - 1));
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (word_q.size() > 0) begin
        next_word = word_q.pop_front();
        in_valid <= 1'b1;
        cmd <= next_word.op;
        x_coord <= next_word.x;
        y_coord <= next_word.y;
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) send_calm = 40;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        stall_nxt = 1'b1;
      end else if (!hold_done && verdicts_seen >= 20) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        stall_nxt = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        stall_nxt = 1'b1;
      end else if (recv_calm > 0) begin
        recv_calm--;
        stall_nxt = 1'b0;
      end else begin
        stall_nxt = 1'b0;
        recv_gap = pick_gap();
        if ($urandom_range(0, 39) == 0) recv_calm = 50;
      end
      out_stall <= stall_nxt;
    end
  end

  // check verdicts, then predict from accepted words
  always @(posedge clk) begin
    tcnc_pkg::verdict_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("verdict %0d with none expected", verdict));
        end else begin
          want = verdict_q.pop_front();
          if (verdict !== want)
            flag_error($sformatf("verdict expected %0d got %0d", want, verdict));
        end
      end
      if (in_valid && !in_stall) begin
        absorb_word(tcnc_pkg::cmd_t'(cmd), x_coord, y_coord);
        words_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n_add, n_cls, r;
    bit narrow;

    // directed: empty clusters, extremes, ties, clear
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd0, 8'd0);
    push_word(tcnc_pkg::CMD_ADD_A, 8'd0, 8'd0);
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd255, 8'd255);
    push_word(tcnc_pkg::CMD_ADD_B, 8'd255, 8'd255);
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd0, 8'd0);
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd255, 8'd255);
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd127, 8'd128);
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd255, 8'd0);
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd0, 8'd255);
    push_word(tcnc_pkg::CMD_ADD_A, 8'd255, 8'd0);
    push_word(tcnc_pkg::CMD_ADD_B, 8'd0, 8'd255);
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd128, 8'd128);
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd200, 8'd10);
    push_word(tcnc_pkg::CMD_CLEAR, 8'd255, 8'd255);
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd1, 8'd1);
    push_word(tcnc_pkg::CMD_ADD_B, 8'd3, 8'd3);
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd3, 8'd3);
    push_word(tcnc_pkg::CMD_ADD_A, 8'd1, 8'd1);
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd2, 8'd2);
    push_word(tcnc_pkg::CMD_CLASSIFY, 8'd0, 8'd0);
    push_word(tcnc_pkg::CMD_CLEAR, 8'd0, 8'd0);

    // random: mostly fill-then-query sequences, some noise
    while (words_total < 400) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        narrow = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 1))
          push_word(tcnc_pkg::CMD_CLEAR, pick_coord(0), pick_coord(0));
        n_add = $urandom_range(1, 14);
        repeat (n_add)
          push_word($urandom_range(0, 1) ? tcnc_pkg::CMD_ADD_B : tcnc_pkg::CMD_ADD_A,
                    pick_coord(narrow), pick_coord(narrow));
        n_cls = $urandom_range(1, 5);
        repeat (n_cls)
          push_word(tcnc_pkg::CMD_CLASSIFY, pick_coord(narrow), pick_coord(narrow));
      end else begin
        repeat ($urandom_range(1, 6))
          push_word(tcnc_pkg::cmd_t'($urandom_range(0, 3)), pick_coord(0), pick_coord(0));
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (words_taken < words_total) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
